// ===== hw/rtl/gea_pkg.sv =====
// Shared types, constants and helpers for the gimbal earth attitude datapath.
// No dependencies; used by every datapath module of the block.
package gea_pkg;

  localparam int unsigned AngleBitsDef  = 16;
  localparam int unsigned CordicIterDef = 16;
  localparam int unsigned FieldW        = 16;
  localparam int unsigned TrigW         = 18;
  localparam int unsigned SqrtSteps     = 17;

  typedef logic signed [TrigW-1:0] trig_t;

  localparam trig_t InvGainQ16 = 18'sd39797;
  localparam trig_t OneQ16     = 18'sd65536;
  localparam trig_t NegOneQ16  = -18'sd65536;
  localparam trig_t TrigMax    = 18'sd131071;
  localparam trig_t TrigMin    = -18'sd131072;

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sc_t;

  typedef enum logic [1:0] {
    PS_ATAN,
    PS_NEG_HALF,
    PS_POS_HALF
  } pitch_sel_e;

  function automatic logic [31:0] atan_phase(input int unsigned idx);
    case (idx)
      0:       return 32'h20000000;
      1:       return 32'h12E4051E;
      2:       return 32'h09FB385B;
      3:       return 32'h051111D4;
      4:       return 32'h028B0D43;
      5:       return 32'h0145D7E1;
      6:       return 32'h00A2F61E;
      7:       return 32'h00517C55;
      8:       return 32'h0028BE53;
      9:       return 32'h00145F2F;
      10:      return 32'h000A2F98;
      11:      return 32'h000517CC;
      12:      return 32'h00028BE6;
      13:      return 32'h000145F3;
      14:      return 32'h0000A2FA;
      15:      return 32'h0000517D;
      16:      return 32'h000028BE;
      17:      return 32'h0000145F;
      18:      return 32'h00000A30;
      19:      return 32'h00000518;
      20:      return 32'h0000028C;
      21:      return 32'h00000146;
      22:      return 32'h000000A3;
      23:      return 32'h00000051;
      default: return 32'h00000000;
    endcase
  endfunction

  function automatic logic [31:0] angle_in(input logic [FieldW-1:0] f,
                                           input int unsigned ab);
    logic [31:0] w;
    logic [31:0] m;
    w = {16'b0, f};
    m = w & ((32'd1 << ab) - 32'd1);
    return m << (32 - ab);
  endfunction

  function automatic logic [FieldW-1:0] angle_out(input logic [31:0] ph,
                                                  input int unsigned ab);
    logic [31:0] r;
    logic [31:0] s;
    r = ph + (32'd1 << (31 - ab));
    s = r >> (32 - ab);
    return s[FieldW-1:0];
  endfunction

endpackage

// ===== hw/rtl/gimbal_earth_attitude_from_encoders.sv =====
// Gimbal earth-frame attitude: vehicle Euler 3-2-1 and gimbal joint Euler 3-1-2
// angles in, earth-frame Euler 3-2-1 gimbal roll, pitch and yaw out.
// Depends on gea_pkg, gea_sincos, gea_matrix, gea_isqrt, gea_atan2.
//
// Usage:
//   Input channel in_valid_i / in_ready_o carries six 16-bit binary angles per
//   beat; output channel out_valid_o / out_ready_i carries three.
//   One fully pipelined datapath: six sine/cosine CORDICs, a three-stage matrix
//   build and product, a 17-stage square root for the pitch leg, and atan2
//   CORDICs. Throughput is one beat per cycle while the output is not stalled;
//   every stage advances together.
//   in_ready_o is high whenever the output register is empty or being taken,
//   so a new beat enters while a finished result waits in the same cycle
//   it is taken.
//   When the receiver stalls with a result held, the whole pipeline holds;
//   nothing is dropped or repeated, and the held result stays unchanged.
//   Reset clears all valid bits; the pipeline is empty and ready after reset.
//   Pitch at or beyond the pole is clamped to plus or minus a quarter turn.
module gimbal_earth_attitude_from_encoders #(
  parameter int unsigned ANGLE_BITS        = gea_pkg::AngleBitsDef,
  parameter int unsigned CORDIC_ITERATIONS = gea_pkg::CordicIterDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [gea_pkg::FieldW-1:0] fc_roll_i,
  input  logic signed [gea_pkg::FieldW-1:0] fc_pitch_i,
  input  logic signed [gea_pkg::FieldW-1:0] fc_yaw_i,
  input  logic signed [gea_pkg::FieldW-1:0] enc_roll_i,
  input  logic signed [gea_pkg::FieldW-1:0] enc_pitch_i,
  input  logic signed [gea_pkg::FieldW-1:0] enc_yaw_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [gea_pkg::FieldW-1:0] out_roll_o,
  output logic signed [gea_pkg::FieldW-1:0] out_pitch_o,
  output logic signed [gea_pkg::FieldW-1:0] out_yaw_o
);
  import gea_pkg::*;

  localparam int unsigned Lat    = 2 * CORDIC_ITERATIONS + 24;
  localparam int unsigned SqDly  = SqrtSteps + 1;
  localparam int unsigned SelDly = CORDIC_ITERATIONS + 19;

  logic           en;
  logic [Lat-1:0] vld_q;

  assign en          = !vld_q[Lat-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  sc_t fr, fp, fy, e2, e3, e1;

  gea_sincos #(.Iters(CORDIC_ITERATIONS)) u_sc_fr (
    .clk_i, .en_i(en), .phase_i(angle_in(fc_roll_i, ANGLE_BITS)), .sc_o(fr));
  gea_sincos #(.Iters(CORDIC_ITERATIONS)) u_sc_fp (
    .clk_i, .en_i(en), .phase_i(angle_in(fc_pitch_i, ANGLE_BITS)), .sc_o(fp));
  gea_sincos #(.Iters(CORDIC_ITERATIONS)) u_sc_fy (
    .clk_i, .en_i(en), .phase_i(angle_in(fc_yaw_i, ANGLE_BITS)), .sc_o(fy));
  gea_sincos #(.Iters(CORDIC_ITERATIONS)) u_sc_e2 (
    .clk_i, .en_i(en), .phase_i(angle_in(enc_roll_i, ANGLE_BITS)), .sc_o(e2));
  gea_sincos #(.Iters(CORDIC_ITERATIONS)) u_sc_e3 (
    .clk_i, .en_i(en), .phase_i(angle_in(enc_pitch_i, ANGLE_BITS)), .sc_o(e3));
  gea_sincos #(.Iters(CORDIC_ITERATIONS)) u_sc_e1 (
    .clk_i, .en_i(en), .phase_i(angle_in(enc_yaw_i, ANGLE_BITS)), .sc_o(e1));

  trig_t m00, m10, m20, m21, m22;

  gea_matrix u_matrix (
    .clk_i, .en_i(en),
    .fr_i(fr), .fp_i(fp), .fy_i(fy), .e2_i(e2), .e3_i(e3), .e1_i(e1),
    .m00_o(m00), .m10_o(m10), .m20_o(m20), .m21_o(m21), .m22_o(m22));

  // roll and yaw legs
  logic [31:0] roll_ph, yaw_ph;

  gea_atan2 #(.Iters(CORDIC_ITERATIONS)) u_at_roll (
    .clk_i, .en_i(en), .y_i(m21), .x_i(m22), .phase_o(roll_ph));
  gea_atan2 #(.Iters(CORDIC_ITERATIONS)) u_at_yaw (
    .clk_i, .en_i(en), .y_i(m10), .x_i(m00), .phase_o(yaw_ph));

  logic [FieldW-1:0] roll_dly_q [SqDly];
  logic [FieldW-1:0] yaw_dly_q  [SqDly];

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_dly_q[0] <= angle_out(roll_ph, ANGLE_BITS);
      yaw_dly_q[0]  <= angle_out(yaw_ph, ANGLE_BITS);
      for (int k = 1; k < SqDly; k++) begin
        roll_dly_q[k] <= roll_dly_q[k-1];
        yaw_dly_q[k]  <= yaw_dly_q[k-1];
      end
    end
  end

  // pitch leg
  logic signed [2*TrigW-1:0] vsq;
  logic signed [36:0]        n_full;
  logic [16:0]               root;
  pitch_sel_e                psel_d;
  pitch_sel_e                psel_q [SelDly];
  trig_t                     v_q    [SqDly];
  logic [31:0]               pitch_ph;

  assign vsq    = m20 * m20;
  assign n_full = 37'sh1_0000_0000 - 37'(vsq);

  gea_isqrt u_isqrt (
    .clk_i, .en_i(en), .n_i(n_full[32:0]), .r_o(root));

  always_comb begin
    if (m20 >= OneQ16) begin
      psel_d = PS_NEG_HALF;
    end else if (m20 <= NegOneQ16) begin
      psel_d = PS_POS_HALF;
    end else begin
      psel_d = PS_ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_q[0]    <= m20;
      psel_q[0] <= psel_d;
      for (int k = 1; k < SqDly; k++) begin
        v_q[k] <= v_q[k-1];
      end
      for (int k = 1; k < SelDly; k++) begin
        psel_q[k] <= psel_q[k-1];
      end
    end
  end

  gea_atan2 #(.Iters(CORDIC_ITERATIONS)) u_at_pitch (
    .clk_i, .en_i(en), .y_i(v_q[SqDly-1]), .x_i({1'b0, root}), .phase_o(pitch_ph));

  logic [FieldW-1:0] pitch_d;

  always_comb begin
    case (psel_q[SelDly-1])
      PS_NEG_HALF: pitch_d = FieldW'(32'd0 - (32'd1 << (ANGLE_BITS - 2)));
      PS_POS_HALF: pitch_d = FieldW'(32'd1 << (ANGLE_BITS - 2));
      default:     pitch_d = angle_out(32'd0 - pitch_ph, ANGLE_BITS);
    endcase
  end

  // output register
  logic [FieldW-1:0] roll_q, pitch_q, yaw_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_dly_q[SqDly-1];
      pitch_q <= pitch_d;
      yaw_q   <= yaw_dly_q[SqDly-1];
    end
  end

  assign out_roll_o  = roll_q;
  assign out_pitch_o = pitch_q;
  assign out_yaw_o   = yaw_q;

endmodule

// ===== hw/rtl/gea_sincos.sv =====
// Pipelined CORDIC sine and cosine, one micro-rotation per register stage.
// Depends on gea_pkg.
module gea_sincos #(
  parameter int unsigned Iters = gea_pkg::CordicIterDef
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [31:0]  phase_i,
  output gea_pkg::sc_t sc_o
);
  import gea_pkg::*;

  localparam int unsigned XW = 20;
  localparam int unsigned ZW = 34;

  logic signed [XW-1:0] x_q [Iters+1];
  logic signed [XW-1:0] y_q [Iters+1];
  logic signed [ZW-1:0] z_q [Iters+1];
  logic                 flip_q [Iters+1];
  logic                 flip_d;
  logic [31:0]          fold_d;

  assign flip_d = (phase_i[31:30] == 2'b01) || (phase_i[31:30] == 2'b10);
  assign fold_d = flip_d ? phase_i + 32'h8000_0000 : phase_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= XW'(InvGainQ16);
      y_q[0]    <= '0;
      z_q[0]    <= {{(ZW-32){fold_d[31]}}, fold_d};
      flip_q[0] <= flip_d;
    end
  end

  for (genvar i = 0; i < Iters; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ZW'(atan_phase(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ZW'(atan_phase(i));
        end
      end
    end
  end

  assign sc_o.s = flip_q[Iters] ? TrigW'(-y_q[Iters]) : TrigW'(y_q[Iters]);
  assign sc_o.c = flip_q[Iters] ? TrigW'(-x_q[Iters]) : TrigW'(x_q[Iters]);

endmodule

// ===== hw/rtl/gea_matrix.sv =====
// Three-stage rotation matrix build and product: pair products, triple products
// with matrix terms, then the five needed product terms. Depends on gea_pkg.
module gea_matrix (
  input  logic           clk_i,
  input  logic           en_i,
  input  gea_pkg::sc_t   fr_i,
  input  gea_pkg::sc_t   fp_i,
  input  gea_pkg::sc_t   fy_i,
  input  gea_pkg::sc_t   e2_i,
  input  gea_pkg::sc_t   e3_i,
  input  gea_pkg::sc_t   e1_i,
  output gea_pkg::trig_t m00_o,
  output gea_pkg::trig_t m10_o,
  output gea_pkg::trig_t m20_o,
  output gea_pkg::trig_t m21_o,
  output gea_pkg::trig_t m22_o
);
  import gea_pkg::*;

  localparam int unsigned MatW = 20;
  localparam int unsigned AccW = 2 * MatW + 2;

  typedef logic signed [MatW-1:0] mat_t;

  function automatic trig_t mulq(input trig_t a, input trig_t b);
    logic signed [2*TrigW-1:0] p;
    p = a * b;
    return TrigW'(p >>> 16);
  endfunction

  function automatic trig_t mdot(input mat_t a0, input mat_t a1, input mat_t a2,
                                 input mat_t b0, input mat_t b1, input mat_t b2);
    logic signed [AccW-1:0] acc;
    logic signed [AccW-1:0] sh;
    acc = AccW'(a0) * AccW'(b0) + AccW'(a1) * AccW'(b1) + AccW'(a2) * AccW'(b2);
    sh  = acc >>> 16;
    if (sh > AccW'(TrigMax)) return TrigMax;
    if (sh < AccW'(TrigMin)) return TrigMin;
    return TrigW'(sh);
  endfunction

  // stage 1
  trig_t srsp_q, crsp_q, cpcy_q, cpsy_q, crsy_q, srsy_q, crcy_q, srcy_q, srcp_q, crcp_q;
  trig_t sy_q, cy_q, sp_q;
  trig_t s1s2_q, c3s2_q, s3s2_q, s2c1_q, c1c3_q, c2s1_q, s3c1_q, c3s1_q;
  trig_t c1c2_q, s1s3_q, s3c2_q, c3c2_q;
  trig_t s1_q, c1_q, s2_q, s3_q, c3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      srsp_q <= mulq(fr_i.s, fp_i.s);
      crsp_q <= mulq(fr_i.c, fp_i.s);
      cpcy_q <= mulq(fp_i.c, fy_i.c);
      cpsy_q <= mulq(fp_i.c, fy_i.s);
      crsy_q <= mulq(fr_i.c, fy_i.s);
      srsy_q <= mulq(fr_i.s, fy_i.s);
      crcy_q <= mulq(fr_i.c, fy_i.c);
      srcy_q <= mulq(fr_i.s, fy_i.c);
      srcp_q <= mulq(fr_i.s, fp_i.c);
      crcp_q <= mulq(fr_i.c, fp_i.c);
      sy_q   <= fy_i.s;
      cy_q   <= fy_i.c;
      sp_q   <= fp_i.s;
      s1s2_q <= mulq(e1_i.s, e2_i.s);
      c3s2_q <= mulq(e3_i.c, e2_i.s);
      s3s2_q <= mulq(e3_i.s, e2_i.s);
      s2c1_q <= mulq(e2_i.s, e1_i.c);
      c1c3_q <= mulq(e1_i.c, e3_i.c);
      c2s1_q <= mulq(e2_i.c, e1_i.s);
      s3c1_q <= mulq(e3_i.s, e1_i.c);
      c3s1_q <= mulq(e3_i.c, e1_i.s);
      c1c2_q <= mulq(e1_i.c, e2_i.c);
      s1s3_q <= mulq(e1_i.s, e3_i.s);
      s3c2_q <= mulq(e3_i.s, e2_i.c);
      c3c2_q <= mulq(e3_i.c, e2_i.c);
      s1_q   <= e1_i.s;
      c1_q   <= e1_i.c;
      s2_q   <= e2_i.s;
      s3_q   <= e3_i.s;
      c3_q   <= e3_i.c;
    end
  end

  // stage 2
  mat_t a_q [3][3];
  mat_t b_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q[0][0] <= MatW'(cpcy_q);
      a_q[0][1] <= MatW'(mulq(srsp_q, cy_q)) - MatW'(crsy_q);
      a_q[0][2] <= MatW'(mulq(crsp_q, cy_q)) + MatW'(srsy_q);
      a_q[1][0] <= MatW'(cpsy_q);
      a_q[1][1] <= MatW'(mulq(srsp_q, sy_q)) + MatW'(crcy_q);
      a_q[1][2] <= MatW'(mulq(crsp_q, sy_q)) - MatW'(srcy_q);
      a_q[2][0] <= -MatW'(sp_q);
      a_q[2][1] <= MatW'(srcp_q);
      a_q[2][2] <= MatW'(crcp_q);
      b_q[0][0] <= MatW'(c1c3_q) - MatW'(mulq(s1s2_q, s3_q));
      b_q[0][1] <= -MatW'(c2s1_q);
      b_q[0][2] <= MatW'(s3c1_q) + MatW'(mulq(c3s2_q, s1_q));
      b_q[1][0] <= MatW'(c3s1_q) + MatW'(mulq(s3s2_q, c1_q));
      b_q[1][1] <= MatW'(c1c2_q);
      b_q[1][2] <= MatW'(s1s3_q) - MatW'(mulq(s2c1_q, c3_q));
      b_q[2][0] <= -MatW'(s3c2_q);
      b_q[2][1] <= MatW'(s2_q);
      b_q[2][2] <= MatW'(c3c2_q);
    end
  end

  // stage 3
  trig_t m00_q, m10_q, m20_q, m21_q, m22_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m00_q <= mdot(a_q[0][0], a_q[0][1], a_q[0][2], b_q[0][0], b_q[1][0], b_q[2][0]);
      m10_q <= mdot(a_q[1][0], a_q[1][1], a_q[1][2], b_q[0][0], b_q[1][0], b_q[2][0]);
      m20_q <= mdot(a_q[2][0], a_q[2][1], a_q[2][2], b_q[0][0], b_q[1][0], b_q[2][0]);
      m21_q <= mdot(a_q[2][0], a_q[2][1], a_q[2][2], b_q[0][1], b_q[1][1], b_q[2][1]);
      m22_q <= mdot(a_q[2][0], a_q[2][1], a_q[2][2], b_q[0][2], b_q[1][2], b_q[2][2]);
    end
  end

  assign m00_o = m00_q;
  assign m10_o = m10_q;
  assign m20_o = m20_q;
  assign m21_o = m21_q;
  assign m22_o = m22_q;

endmodule

// ===== hw/rtl/gea_isqrt.sv =====
// Pipelined integer square root, one result digit per register stage.
// Depends on gea_pkg.
module gea_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [32:0] n_i,
  output logic [16:0] r_o
);
  import gea_pkg::*;

  localparam int unsigned RW = 35;

  logic [32:0]   n_q   [SqrtSteps+1];
  logic [RW-1:0] res_q [SqrtSteps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]   <= n_i;
      res_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    localparam logic [RW-1:0] Bit = RW'(1) << (32 - 2 * k);
    logic [RW-1:0] t_d;
    assign t_d = res_q[k] + Bit;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({2'b0, n_q[k]} >= t_d) begin
          n_q[k+1]   <= n_q[k] - t_d[32:0];
          res_q[k+1] <= (res_q[k] >> 1) + Bit;
        end else begin
          n_q[k+1]   <= n_q[k];
          res_q[k+1] <= res_q[k] >> 1;
        end
      end
    end
  end

  assign r_o = res_q[SqrtSteps][16:0];

endmodule

// ===== hw/rtl/gea_atan2.sv =====
// Pipelined CORDIC vectoring atan2 giving a 32-bit phase, one micro-rotation
// per register stage. Depends on gea_pkg.
module gea_atan2 #(
  parameter int unsigned Iters = gea_pkg::CordicIterDef
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  gea_pkg::trig_t y_i,
  input  gea_pkg::trig_t x_i,
  output logic [31:0]    phase_o
);
  import gea_pkg::*;

  localparam int unsigned W = 36;

  logic signed [W-1:0] x_q [Iters+1];
  logic signed [W-1:0] y_q [Iters+1];
  logic [31:0]         z_q [Iters+1];
  logic signed [W-1:0] xs_d, ys_d;

  assign xs_d = W'(x_i) <<< 14;
  assign ys_d = W'(y_i) <<< 14;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (xs_d[W-1]) begin
        x_q[0] <= -xs_d;
        y_q[0] <= -ys_d;
        z_q[0] <= 32'h8000_0000;
      end else begin
        x_q[0] <= xs_d;
        y_q[0] <= ys_d;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < Iters; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[i][W-1]) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_phase(i);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_phase(i);
        end
      end
    end
  end

  assign phase_o = z_q[Iters];

endmodule

// ===== hw/rtl/gea_checker.sv =====
// Port-level checks for the gimbal earth attitude block, bound to its top level.
// Depends on gimbal_earth_attitude_from_encoders port names only.
module gea_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] out_roll_o,
  input logic [15:0] out_pitch_o,
  input logic [15:0] out_yaw_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(out_roll_o) && $stable(out_pitch_o) && $stable(out_yaw_o))
    else $error("stalled output beat changed");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output drain");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind gimbal_earth_attitude_from_encoders gea_checker u_gea_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking bench for gimbal_earth_attitude_from_encoders: random and corner
// attitude pairs, fixed-point predictor of the rotation composition, random stalls.
// Depends on gea_pkg and the block RTL.
`timescale 1ns / 100ps

class attitude_scoreboard;
  typedef struct {
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
  } euler_t;

  euler_t pending[$];
  int     mismatches;

  function longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function longint qmul(longint a, longint b);
    return fl_shr(a * b, 16);
  endfunction

  function longint clip18(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function logic [31:0] to_phase(logic [15:0] f);
    return {f, 16'h0};
  endfunction

  function logic [15:0] to_angle(logic [31:0] ph);
    logic [31:0] r;
    r = ph + 32'h8000;
    return r[31:16];
  endfunction

  function void sin_cos(logic [31:0] p, output longint s, output longint c);
    bit     flip;
    longint x, y, z, dx, dy;
    flip = (p[31:30] == 2'd1) || (p[31:30] == 2'd2);
    x = 39797;
    y = 0;
    if (flip) p = p + 32'h80000000;
    z = longint'($signed(p));
    for (int i = 0; i < 16; i++) begin
      dx = fl_shr(y, i);
      dy = fl_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(gea_pkg::atan_phase(i));
      end else begin
        x += dx; y -= dy; z += longint'(gea_pkg::atan_phase(i));
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function logic [31:0] vec_angle(longint y, longint x);
    logic [31:0] z;
    longint      dx, dy;
    z = 0;
    x *= 16384;
    y *= 16384;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < 16; i++) begin
      dx = fl_shr(y, i);
      dy = fl_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += gea_pkg::atan_phase(i);
      end else begin
        x -= dx; y += dy; z -= gea_pkg::atan_phase(i);
      end
    end
    return z;
  endfunction

  function longint int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 32;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function void note_beat(logic [15:0] fr, logic [15:0] fp, logic [15:0] fy,
                          logic [15:0] er, logic [15:0] ep, logic [15:0] ey);
    longint sr, cr, sp, cp, sy, cy, s1, c1, s2, c2, s3, c3, v;
    longint a[3][3], b[3][3], m[3][3];
    euler_t e;
    sin_cos(to_phase(fr), sr, cr);
    sin_cos(to_phase(fp), sp, cp);
    sin_cos(to_phase(fy), sy, cy);
    sin_cos(to_phase(er), s2, c2);
    sin_cos(to_phase(ep), s3, c3);
    sin_cos(to_phase(ey), s1, c1);
    a[0][0] = qmul(cp, cy);
    a[0][1] = qmul(qmul(sr, sp), cy) - qmul(cr, sy);
    a[0][2] = qmul(qmul(cr, sp), cy) + qmul(sr, sy);
    a[1][0] = qmul(cp, sy);
    a[1][1] = qmul(qmul(sr, sp), sy) + qmul(cr, cy);
    a[1][2] = qmul(qmul(cr, sp), sy) - qmul(sr, cy);
    a[2][0] = -sp;
    a[2][1] = qmul(sr, cp);
    a[2][2] = qmul(cr, cp);
    b[0][0] = qmul(c1, c3) - qmul(qmul(s1, s2), s3);
    b[0][1] = -qmul(c2, s1);
    b[0][2] = qmul(s3, c1) + qmul(qmul(c3, s2), s1);
    b[1][0] = qmul(c3, s1) + qmul(qmul(s3, s2), c1);
    b[1][1] = qmul(c1, c2);
    b[1][2] = qmul(s1, s3) - qmul(qmul(s2, c1), c3);
    b[2][0] = -qmul(s3, c2);
    b[2][1] = s2;
    b[2][2] = qmul(c3, c2);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i][j] = clip18(fl_shr(a[i][0] * b[0][j] + a[i][1] * b[1][j]
                                + a[i][2] * b[2][j], 16));
    e.roll = to_angle(vec_angle(m[2][1], m[2][2]));
    v = m[2][0];
    if (v >= 65536) e.pitch = 16'hC000;
    else if (v <= -65536) e.pitch = 16'h4000;
    else e.pitch = to_angle(32'd0 - vec_angle(v, int_sqrt(64'd4294967296 - v * v)));
    e.yaw = to_angle(vec_angle(m[1][0], m[0][0]));
    pending.push_back(e);
  endfunction

  function void check_beat(logic [15:0] r, logic [15:0] p, logic [15:0] y);
    euler_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %0d %0d %0d",
                                     $signed(r), $signed(p), $signed(y));
      return;
    end
    e = pending.pop_front();
    if (e.roll !== r || e.pitch !== p || e.yaw !== y) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch exp %0d %0d %0d got %0d %0d %0d", $signed(e.roll),
                 $signed(e.pitch), $signed(e.yaw), $signed(r), $signed(p), $signed(y));
    end
  endfunction
endclass

module tb;
  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [15:0] fc_roll_i, fc_pitch_i, fc_yaw_i;
  logic signed [15:0] enc_roll_i, enc_pitch_i, enc_yaw_i;
  logic signed [15:0] out_roll_o, out_pitch_o, out_yaw_o;

  attitude_scoreboard board;
  bit  calm;
  int  hold_off;

  gimbal_earth_attitude_from_encoders dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("tb NOT OK");
    $finish;
  end

  function logic [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h4000 + 16'($urandom_range(0, 6)) - 16'd3;
      3: return 16'hC000 + 16'($urandom_range(0, 6)) - 16'd3;
      4: return 16'($urandom_range(0, 8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                           logic [15:0] d, logic [15:0] e, logic [15:0] f);
    in_valid_i <= 1;
    fc_roll_i <= a; fc_pitch_i <= b; fc_yaw_i <= c;
    enc_roll_i <= d; enc_pitch_i <= e; enc_yaw_i <= f;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_beat(a, b, c, d, e, f);
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_beat(out_roll_o, out_pitch_o, out_yaw_o);
  end

  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 0;
    end else out_ready_i <= calm || ($urandom_range(0, 99) >= 15);
  end

  initial begin
    logic [15:0] corner[6];
    int          wait_cnt;
    corner = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h0001};
    board = new();
    rst_ni = 0; in_valid_i = 0; out_ready_i = 0; calm = 0; hold_off = 0;
    {fc_roll_i, fc_pitch_i, fc_yaw_i, enc_roll_i, enc_pitch_i, enc_yaw_i} = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (corner[i]) send_beat(corner[i], corner[i], corner[i],
                                  corner[i], corner[i], corner[i]);
    send_beat(16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h0);
    send_beat(16'h0, 16'hC000, 16'h0, 16'h0, 16'h0, 16'h0);
    send_beat(16'h0, 16'h2000, 16'h0, 16'h0, 16'h2000, 16'h0);
    send_beat(16'h0, 16'hE000, 16'h0, 16'h2000, 16'hE000, 16'h8000);
    send_beat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_beat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    send_beat(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    for (int n = 0; n < 1800; n++) begin
      if (n == 300) hold_off = 200;
      calm = (n >= 600 && n < 900);
      idle_gap();
      send_beat(pick_angle(), pick_angle(), pick_angle(),
                pick_angle(), pick_angle(), pick_angle());
    end
    in_valid_i <= 0;
    calm = 0;
    wait_cnt = 0;
    while (board.pending.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (100) @(posedge clk_i);
    if (board.pending.size() == 0 && board.mismatches == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
